@@ src/lcdnw_pkg.sv @@
package lcdnw_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam int MAX_DIGITS  = 16;

  localparam int DIG_W = 4 * MAX_DIGITS;
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W = $clog2(VALUE_WIDTH);

  localparam logic [2:0] OP_CHAR     = 3'd0;
  localparam logic [2:0] OP_UDEC     = 3'd1;
  localparam logic [2:0] OP_SDEC     = 3'd2;
  localparam logic [2:0] OP_HEX      = 3'd3;
  localparam logic [2:0] OP_BIN      = 3'd4;

  localparam logic [7:0] CMD_SET_CURSOR = 8'h80;
  localparam logic [7:0] ROW2_OFFSET    = 8'h40;
  localparam logic [7:0] COL_ADJUST     = 8'hFF;
  localparam logic [7:0] ASCII_ZERO     = 8'h30;
  localparam logic [7:0] ASCII_A        = 8'h41;
  localparam logic [7:0] ASCII_PLUS     = 8'h2B;
  localparam logic [7:0] ASCII_MINUS    = 8'h2D;

  typedef struct packed {
    logic load;
    logic load_hex;
    logic load_bin;
    logic step;
  } digit_ctrl_t;

endpackage

@@ src/lcdnw_digits.sv @@
module lcdnw_digits (
  input  logic                                 clk,
  input  lcdnw_pkg::digit_ctrl_t               ctrl,
  input  logic [lcdnw_pkg::VALUE_WIDTH-1:0]    load_value,
  input  logic [lcdnw_pkg::IDX_W-1:0]          idx,
  output logic [7:0]                           ascii
);

  localparam int VW = lcdnw_pkg::VALUE_WIDTH;
  localparam int DW = lcdnw_pkg::DIG_W;
  localparam int ND = lcdnw_pkg::MAX_DIGITS;

  logic [VW-1:0]    mag_r;
  logic [VW-1:0]    mag_nxt;
  logic [DW-1:0]    dig_r;
  logic [DW-1:0]    dig_nxt;
  logic [DW-1:0]    adj;
  logic [DW-1:0]    load_dig;
  logic [DW+VW-1:0] vwide;
  logic [3:0]       d;

  assign vwide = {{DW{1'b0}}, load_value};

  // Hex and binary digits come straight from the value bits; decimal starts from zero.
  always_comb begin
    load_dig = '0;
    for (int k = 0; k < ND; k++) begin
      if (ctrl.load_hex) begin
        load_dig[4*k +: 4] = vwide[4*k +: 4];
      end else if (ctrl.load_bin) begin
        load_dig[4*k +: 4] = {3'b000, vwide[k]};
      end
    end
  end

  // One double-dabble step: correct every BCD digit, then shift in the next value bit.
  always_comb begin
    for (int k = 0; k < ND; k++) begin
      if (dig_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = dig_r[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = dig_r[4*k +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    dig_nxt = dig_r;
    if (ctrl.load) begin
      mag_nxt = load_value;
      dig_nxt = load_dig;
    end else if (ctrl.step) begin
      mag_nxt = {mag_r[VW-2:0], 1'b0};
      dig_nxt = {adj[DW-2:0], mag_r[VW-1]};
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    dig_r <= dig_nxt;
  end

  assign d = dig_r[idx*4 +: 4];

  always_comb begin
    if (d < 4'd10) begin
      ascii = lcdnw_pkg::ASCII_ZERO + {4'b0000, d};
    end else begin
      ascii = lcdnw_pkg::ASCII_A + {4'b0000, d} - 8'd10;
    end
  end

endmodule

@@ src/char_lcd_number_writer.sv @@
// Character LCD number writer. A request is taken on a clock edge where start is high and
// busy is low; it yields an optional set-cursor command and then the character writes, each
// on the out_ ports for exactly one cycle under out_valid, with out_last on the final one.
// The receiver cannot stall, so every write must be taken in the cycle it appears. Decimal
// modes convert the value with a bit-serial double-dabble register, one value bit per cycle.
// A request yields at most 18 writes, which follow one per cycle. After the last conversion
// cycle the first write passes through the state register and then the output registers,
// and the final one is on the ports in the first cycle with busy low again. Opcodes above
// four are not taken, so busy stays low and nothing is produced.
module char_lcd_number_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [15:0] in_value,
  input  logic [4:0]  in_digit_count,
  output logic        out_valid,
  output logic        out_is_data,
  output logic [7:0]  out_bus_byte,
  output logic        out_last
);

  localparam int VW = lcdnw_pkg::VALUE_WIDTH;
  localparam int CW = lcdnw_pkg::CNT_W;
  localparam int IW = lcdnw_pkg::IDX_W;
  localparam int BW = lcdnw_pkg::BIT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_CURSOR = 3'd2;
  localparam logic [2:0] S_SIGN   = 3'd3;
  localparam logic [2:0] S_DIGITS = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic          has_cur_r, has_cur_nxt;
  logic [7:0]    cur_byte_r, cur_byte_nxt;
  logic          neg_r, neg_nxt;
  logic [7:0]    char_r, char_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [BW-1:0] bit_r, bit_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_is_data_r, out_is_data_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic             accept;
  logic [VW+15:0]   vwide;
  logic [VW-1:0]    v_ext;
  logic [VW-1:0]    mag;
  logic             neg;
  logic [CW-1:0]    cnt_sat;
  logic             has_sign;
  logic             has_dig;
  logic             is_dec;
  logic [2:0]       first_state;
  logic [2:0]       after_cursor;
  logic [7:0]       sign_byte;
  logic [7:0]       digit_ascii;
  lcdnw_pkg::digit_ctrl_t dctrl;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy && (in_opcode <= lcdnw_pkg::OP_BIN);

  assign vwide = {{VW{1'b0}}, in_value};
  assign v_ext = vwide[VW-1:0];
  assign neg   = (in_opcode == lcdnw_pkg::OP_SDEC) && v_ext[VW-1];
  assign mag   = neg ? (~v_ext + {{(VW-1){1'b0}}, 1'b1}) : v_ext;

  always_comb begin
    if (int'(in_digit_count) > lcdnw_pkg::MAX_DIGITS) begin
      cnt_sat = CW'(lcdnw_pkg::MAX_DIGITS);
    end else begin
      cnt_sat = CW'(in_digit_count);
    end
  end

  assign dctrl.load     = accept;
  assign dctrl.load_hex = (in_opcode == lcdnw_pkg::OP_HEX);
  assign dctrl.load_bin = (in_opcode == lcdnw_pkg::OP_BIN);
  assign dctrl.step     = (state_r == S_CONV) && is_dec;

  lcdnw_digits u_digits (
    .clk        (clk),
    .ctrl       (dctrl),
    .load_value (mag),
    .idx        (idx_r),
    .ascii      (digit_ascii)
  );

  assign is_dec   = (op_r == lcdnw_pkg::OP_UDEC) || (op_r == lcdnw_pkg::OP_SDEC);
  assign has_sign = (op_r == lcdnw_pkg::OP_CHAR) || (op_r == lcdnw_pkg::OP_SDEC);
  assign has_dig  = (op_r != lcdnw_pkg::OP_CHAR) && (cnt_r != '0);

  always_comb begin
    if (op_r == lcdnw_pkg::OP_CHAR) begin
      sign_byte = char_r;
    end else if (neg_r) begin
      sign_byte = lcdnw_pkg::ASCII_MINUS;
    end else begin
      sign_byte = lcdnw_pkg::ASCII_PLUS;
    end
  end

  always_comb begin
    if (has_sign) begin
      after_cursor = S_SIGN;
    end else if (has_dig) begin
      after_cursor = S_DIGITS;
    end else begin
      after_cursor = S_IDLE;
    end
    first_state = has_cur_r ? S_CURSOR : after_cursor;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    has_cur_nxt     = has_cur_r;
    cur_byte_nxt    = cur_byte_r;
    neg_nxt         = neg_r;
    char_nxt        = char_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    bit_nxt         = bit_r;
    out_valid_nxt   = 1'b0;
    out_is_data_nxt = 1'b1;
    out_byte_nxt    = digit_ascii;
    out_last_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_CONV;
          op_nxt       = in_opcode;
          has_cur_nxt  = (in_row == 2'd1) || (in_row == 2'd2);
          cur_byte_nxt = lcdnw_pkg::CMD_SET_CURSOR |
                         ({2'b00, in_col} + lcdnw_pkg::COL_ADJUST +
                          ((in_row == 2'd2) ? lcdnw_pkg::ROW2_OFFSET : 8'h00));
          neg_nxt      = neg;
          char_nxt     = in_value[7:0];
          cnt_nxt      = cnt_sat;
          idx_nxt      = IW'(cnt_sat - CW'(1));
          bit_nxt      = BW'(VW - 1);
        end
      end
      S_CONV: begin
        if (!is_dec || (bit_r == '0)) begin
          state_nxt = first_state;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      S_CURSOR: begin
        out_valid_nxt   = 1'b1;
        out_is_data_nxt = 1'b0;
        out_byte_nxt    = cur_byte_r;
        out_last_nxt    = (after_cursor == S_IDLE);
        state_nxt       = after_cursor;
      end
      S_SIGN: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = sign_byte;
        out_last_nxt  = !has_dig;
        state_nxt     = has_dig ? S_DIGITS : S_IDLE;
      end
      S_DIGITS: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = digit_ascii;
        out_last_nxt  = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r - IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    has_cur_r     <= has_cur_nxt;
    cur_byte_r    <= cur_byte_nxt;
    neg_r         <= neg_nxt;
    char_r        <= char_nxt;
    cnt_r         <= cnt_nxt;
    idx_r         <= idx_nxt;
    bit_r         <= bit_nxt;
    out_is_data_r <= out_is_data_nxt;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_data  = out_is_data_r;
  assign out_bus_byte = out_byte_r;
  assign out_last     = out_last_r;

  // The writes of one request arrive in consecutive cycles.
  a_burst_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("transfer burst broken before last");

  // A final write is never directly followed by another one.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("transfer directly after last");

  // An accepted request always passes through the conversion state before its first write.
  a_no_write_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("transfer in the cycle after accept");

  // Every write comes from a cycle in which the block was busy.
  a_write_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) |-> $past(busy))
    else $error("transfer without a request in progress");

endmodule
